// ----- sv/assert_macros.svh -----
// Assertion macros used by the top level of the Modbus CRC appender.
// Standalone header; the including module must provide clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define MFCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks a property at every rising clock edge, reset included.
`define MFCA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- sv/mfca_pkg.sv -----
// Package of the Modbus CRC appender: CRC constants, the byte fold function,
// the beat phase type and the fold result struct. No dependencies.
package mfca_pkg;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [8:0]  PosLength = 9'd2;
  localparam logic [8:0]  PosFirstData = 9'd3;

  typedef enum logic [1:0] {
    PH_DATA   = 2'd0,
    PH_CRC_LO = 2'd1,
    PH_CRC_HI = 2'd2
  } phase_e;

  typedef struct packed {
    logic [15:0] crc;
    logic        done;
  } fold_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- sv/mfca_frame_track.sv -----
// Frame tracker: running CRC, byte position and length of the current frame.
// Depends on mfca_pkg.
module mfca_frame_track (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  output mfca_pkg::fold_t     fold_o
);

  logic [15:0] crc_q, crc_d, crc_new;
  logic [8:0]  pos_q, pos_d;
  logic [7:0]  len_q, len_d;
  logic        done;

  always_comb begin
    crc_new = mfca_pkg::crc_fold(crc_q, byte_i);
    done    = 1'b0;
    pos_d   = pos_q;
    len_d   = len_q;
    if (pos_q < mfca_pkg::PosLength) begin
      pos_d = pos_q + 9'd1;
    end else if (pos_q == mfca_pkg::PosLength) begin
      len_d = byte_i;
      if (byte_i == 8'h00) begin
        done = 1'b1;
      end else begin
        pos_d = mfca_pkg::PosFirstData;
      end
    end else begin
      if (pos_q >= ({1'b0, len_q} + mfca_pkg::PosLength)) begin
        done = 1'b1;
      end else begin
        pos_d = pos_q + 9'd1;
      end
    end
    crc_d = crc_new;
    if (done) begin
      crc_d = mfca_pkg::CrcInit;
      pos_d = 9'd0;
      len_d = 8'h00;
    end
  end

  assign fold_o.crc  = crc_new;
  assign fold_o.done = done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= mfca_pkg::CrcInit;
      pos_q <= 9'd0;
      len_q <= 8'h00;
    end else if (step_i) begin
      crc_q <= crc_d;
      pos_q <= pos_d;
      len_q <= len_d;
    end
  end

endmodule

// ----- sv/modbus_frame_crc_appender_unit.sv -----
// Top level of the Modbus CRC appender: input register, frame tracker and
// result register with CRC beat sequencing. Depends on mfca_pkg,
// mfca_frame_track and assert_macros.svh.
//
// Frame bytes (address, function, length, then that many data bytes) pass
// through unchanged, one beat per cycle when the output is not stalled, via
// the input register and the result register. After the last byte of a frame
// (the final data byte, or the length byte when it is zero) two CRC-16/MODBUS
// beats follow, low byte first, the high byte flagged by out_frame_end_o; the
// CRC then restarts at 0xFFFF. Ordinary bytes go through at one per cycle
// unless the output stalls; the byte that closes a frame occupies the result
// register for three output beats, and the input is held off meanwhile.
`include "assert_macros.svh"

module modbus_frame_crc_appender_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_frame_end_o
);

  logic                in_valid_q;
  logic [7:0]          in_byte_q;
  logic                out_valid_q;
  logic [7:0]          out_data_q;
  logic [15:0]         out_crc_q;
  logic                out_done_q;
  mfca_pkg::phase_e    phase_q, phase_d;
  mfca_pkg::fold_t     fold;
  logic                pop, last_pop, advance;

  assign pop      = out_valid_q && !out_stall_i;
  assign last_pop = pop && (((phase_q == mfca_pkg::PH_DATA) && !out_done_q) ||
                            (phase_q == mfca_pkg::PH_CRC_HI));
  assign advance  = !out_valid_q || last_pop;
  assign in_stall_o = in_valid_q && !advance;

  mfca_frame_track u_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance && in_valid_q),
    .byte_i (in_byte_q),
    .fold_o (fold)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= mfca_pkg::PH_DATA;
    end else begin
      phase_q <= phase_d;
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_data_q <= in_byte_q;
      out_crc_q  <= fold.crc;
      out_done_q <= fold.done;
    end
  end

  always_comb begin
    phase_d = phase_q;
    if (advance) begin
      phase_d = mfca_pkg::PH_DATA;
    end else if (pop) begin
      case (phase_q)
        mfca_pkg::PH_DATA:   phase_d = mfca_pkg::PH_CRC_LO;
        mfca_pkg::PH_CRC_LO: phase_d = mfca_pkg::PH_CRC_HI;
        default:             phase_d = mfca_pkg::PH_DATA;
      endcase
    end
  end

  always_comb begin
    out_valid_o     = out_valid_q;
    out_frame_end_o = 1'b0;
    case (phase_q)
      mfca_pkg::PH_DATA:   out_byte_o = out_data_q;
      mfca_pkg::PH_CRC_LO: out_byte_o = out_crc_q[7:0];
      mfca_pkg::PH_CRC_HI: begin
        out_byte_o      = out_crc_q[15:8];
        out_frame_end_o = 1'b1;
      end
      default:             out_byte_o = out_data_q;
    endcase
  end

  `MFCA_ASSERT(a_crc_beat_needs_done, (phase_q != mfca_pkg::PH_DATA) |-> (out_valid_q && out_done_q), "CRC beat without a finished frame")
  `MFCA_ASSERT(a_lo_then_hi, (pop && (phase_q == mfca_pkg::PH_CRC_LO)) |=> (out_valid_o && out_frame_end_o), "CRC low beat not followed by the high beat")
  `MFCA_ASSERT(a_stall_when_full, in_stall_o |-> (in_valid_q && out_valid_q), "input stalled with room to advance")
  `MFCA_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule
